// ===== hdl/nsff_pkg.sv =====
// Package for the NMEA sentence fix filter: character codes, column numbers,
// header patterns, the result record type and the digit pair decoder.
// No dependencies.
package nsff_pkg;

   // Line buffer capacity in bytes and the width of the line byte counter.
   localparam int LINE_CAPACITY = 512;
   localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
   localparam int LINE_LENGTH_W = 10;

   // Character codes.
   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_DOLLAR = 8'h24;
   localparam logic [7:0] BYTE_COMMA  = 8'h2C;
   localparam logic [7:0] BYTE_ZERO   = 8'h30;
   localparam logic [7:0] BYTE_A      = 8'h41;

   // Header patterns, first character in the top byte.
   localparam logic [47:0] HDR_GPRMC = "$GPRMC";
   localparam logic [47:0] HDR_GNRMC = "$GNRMC";
   localparam logic [47:0] HDR_GPGGA = "$GPGGA";
   localparam logic [47:0] HDR_GNGGA = "$GNGGA";
   localparam int          HDR_LEN   = 6;

   // Column numbers counted in commas from the start of the line.
   localparam logic [3:0] COL_HMS   = 4'd1;
   localparam logic [3:0] COL_VALID = 4'd2;
   localparam logic [3:0] COL_TYPE  = 4'd6;
   localparam logic [3:0] COL_YMD   = 4'd9;
   localparam logic [3:0] COL_MAX   = 4'd15;
   localparam logic [2:0] OFFSET_MAX = 3'd7;

   // Digit capture covers six bytes; position six means idle.
   localparam int         CAP_LEN  = 6;
   localparam logic [2:0] CAP_IDLE = 3'd6;

   // Sentence kinds.
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_GGA   = 2'd1;
   localparam logic [1:0] KIND_RMC   = 2'd2;

   // Configuration register word index.
   localparam logic CSR_SYNC_INTERVAL = 1'b0;

   // One verdict record per finished line.
   typedef struct packed {
      logic [LINE_LENGTH_W-1:0] line_length;
      logic [1:0]               sentence_kind;
      logic                     keep_line;
      logic                     logging_started;
      logic [6:0]               fix_hour;
      logic [6:0]               fix_minute;
      logic [6:0]               fix_second;
      logic [6:0]               fix_day;
      logic [6:0]               fix_month;
      logic [6:0]               fix_year;
      logic                     sync_request;
   } nsff_result_type;

   // Two ASCII digits to their value; anything else gives zero.
   function automatic logic [6:0] digit_pair(input logic [7:0] hi_c, input logic [7:0] lo_c);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [6:0] val;
      hi  = hi_c - BYTE_ZERO;
      lo  = lo_c - BYTE_ZERO;
      val = 7'({hi[3:0], 3'b000}) + 7'({hi[3:0], 1'b0}) + 7'(lo[3:0]);
      if (hi < 8'd10 && lo < 8'd10) begin
         return val;
      end
      return 7'd0;
   endfunction

   // Compare six captured header bytes with a pattern.
   function automatic logic header_is(input logic [5:0][7:0] hdr, input logic [47:0] pat);
      logic match;
      match = 1'b1;
      for (int i = 0; i < HDR_LEN; i++) begin
         if (hdr[i] != pat[47-8*i -: 8]) begin
            match = 1'b0;
         end
      end
      return match;
   endfunction

endpackage

// ===== hdl/nsff_line_parser.sv =====
// Line parser of the NMEA sentence fix filter: running line state, column
// search, digit capture, mode and sync counter, and the verdict per line.
// Depends on nsff_pkg.
module nsff_line_parser
   import nsff_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic [7:0]      rx_byte,
   input  logic [15:0]     sync_interval,
   output logic            result_valid,
   output nsff_result_type result
);

   // Line state.
   logic [LEN_W-1:0] count_ff, count_in;
   logic [5:0][7:0]  header_ff, header_in;
   logic [3:0]       col_idx_ff, col_idx_in;
   logic             stopped_ff, stopped_in;
   logic [2:0]       col_off_ff, col_off_in;
   logic [7:0]       valid_char_ff, valid_char_in;
   logic [7:0]       type_char_ff, type_char_in;
   logic [5:0][7:0]  time_ff, time_in;
   logic [5:0][7:0]  date_ff, date_in;
   logic [2:0]       cap_pos_ff, cap_pos_in;
   logic             cap_date_ff, cap_date_in;

   // Mode state.
   logic             logging_ff, logging_in;
   logic [15:0]      lines_ff, lines_in;

   // Updated values before the end-of-line clear.
   logic [LEN_W-1:0] count_upd;
   logic [5:0][7:0]  header_upd;
   logic [3:0]       col_idx_upd;
   logic             stopped_upd;
   logic [2:0]       col_off_upd;
   logic [7:0]       valid_char_upd;
   logic [7:0]       type_char_upd;
   logic [5:0][7:0]  time_upd;
   logic [5:0][7:0]  date_upd;
   logic [2:0]       cap_pos_eff, cap_pos_upd;
   logic             cap_date_eff;

   logic             take, line_end, line_full, first_byte, start_log;
   logic [1:0]       kind;
   logic             keep;
   logic [16:0]      lines_next;
   logic             sync;

   // Byte filter: zero bytes and bytes ahead of a leading '$' are dropped.
   assign take = step_en && (rx_byte != BYTE_NUL)
                 && !(count_ff == '0 && rx_byte != BYTE_DOLLAR);

   // Per-byte update of the column search and captures.
   always_comb begin
      count_upd      = count_ff + LEN_W'(1);
      header_upd     = header_ff;
      valid_char_upd = valid_char_ff;
      type_char_upd  = type_char_ff;
      time_upd       = time_ff;
      date_upd       = date_ff;
      col_idx_upd    = col_idx_ff;
      stopped_upd    = stopped_ff;
      col_off_upd    = col_off_ff;
      cap_pos_eff    = cap_pos_ff;
      cap_date_eff   = cap_date_ff;
      cap_pos_upd    = cap_pos_ff;

      for (int i = 0; i < HDR_LEN; i++) begin
         if (count_ff == LEN_W'(i)) begin
            header_upd[i] = rx_byte;
         end
      end

      // First byte of a column that was found.
      first_byte = !stopped_ff && (col_off_ff == 3'd0);
      if (first_byte) begin
         if (col_idx_ff == COL_VALID) begin
            valid_char_upd = rx_byte;
         end else if (col_idx_ff == COL_TYPE) begin
            type_char_upd = rx_byte;
         end else if (col_idx_ff == COL_HMS || col_idx_ff == COL_YMD) begin
            cap_pos_eff  = 3'd0;
            cap_date_eff = (col_idx_ff == COL_YMD);
         end
      end

      // Raw byte capture for the time and date digit pairs.
      if (cap_pos_eff < CAP_IDLE) begin
         for (int i = 0; i < CAP_LEN; i++) begin
            if (cap_pos_eff == 3'(i)) begin
               if (cap_date_eff) begin
                  date_upd[i] = rx_byte;
               end else begin
                  time_upd[i] = rx_byte;
               end
            end
         end
         cap_pos_upd = cap_pos_eff + 3'd1;
      end

      // Comma counting; a control byte or space stops the search.
      if (!stopped_ff) begin
         if (rx_byte == BYTE_COMMA) begin
            if (col_idx_ff < COL_MAX) begin
               col_idx_upd = col_idx_ff + 4'd1;
            end
            col_off_upd = 3'd0;
         end else if (rx_byte <= BYTE_SPACE) begin
            stopped_upd = 1'b1;
         end else if (col_off_ff < OFFSET_MAX) begin
            col_off_upd = col_off_ff + 3'd1;
         end
      end
   end

   assign line_end  = take && (rx_byte == BYTE_LF);
   assign line_full = take && (count_upd >= LEN_W'(LINE_CAPACITY));

   // Verdict for a finished line.
   always_comb begin
      if (header_is(header_upd, HDR_GPGGA) || header_is(header_upd, HDR_GNGGA)) begin
         kind = KIND_GGA;
      end else if (header_is(header_upd, HDR_GPRMC) || header_is(header_upd, HDR_GNRMC)) begin
         kind = KIND_RMC;
      end else begin
         kind = KIND_OTHER;
      end

      case (kind)
         KIND_GGA: keep = (type_char_upd != BYTE_NUL) && (type_char_upd != BYTE_ZERO);
         KIND_RMC: keep = (valid_char_upd == BYTE_A);
         default:  keep = 1'b0;
      endcase

      start_log  = !logging_ff && (kind == KIND_RMC) && (valid_char_upd == BYTE_A);
      lines_next = {1'b0, lines_ff} + 17'd1;
      sync       = logging_ff && (lines_next > {1'b0, sync_interval});
   end

   assign result_valid = line_end;

   always_comb begin
      result                 = '0;
      result.line_length     = LINE_LENGTH_W'(count_upd);
      result.sentence_kind   = kind;
      result.keep_line       = logging_ff && keep;
      result.logging_started = start_log;
      result.sync_request    = sync;
      if (start_log) begin
         result.fix_hour   = digit_pair(time_upd[0], time_upd[1]);
         result.fix_minute = digit_pair(time_upd[2], time_upd[3]);
         result.fix_second = digit_pair(time_upd[4], time_upd[5]);
         result.fix_day    = digit_pair(date_upd[0], date_upd[1]);
         result.fix_month  = digit_pair(date_upd[2], date_upd[3]);
         result.fix_year   = digit_pair(date_upd[4], date_upd[5]);
      end
   end

   // Next line state: hold, update, or clear at line end or a full line.
   always_comb begin
      count_in      = count_ff;
      header_in     = header_ff;
      col_idx_in    = col_idx_ff;
      stopped_in    = stopped_ff;
      col_off_in    = col_off_ff;
      valid_char_in = valid_char_ff;
      type_char_in  = type_char_ff;
      time_in       = time_ff;
      date_in       = date_ff;
      cap_pos_in    = cap_pos_ff;
      cap_date_in   = cap_date_ff;
      if (line_end || line_full) begin
         count_in      = '0;
         header_in     = '0;
         col_idx_in    = 4'd0;
         stopped_in    = 1'b0;
         col_off_in    = 3'd0;
         valid_char_in = BYTE_NUL;
         type_char_in  = BYTE_NUL;
         time_in       = '0;
         date_in       = '0;
         cap_pos_in    = CAP_IDLE;
         cap_date_in   = 1'b0;
      end else if (take) begin
         count_in      = count_upd;
         header_in     = header_upd;
         col_idx_in    = col_idx_upd;
         stopped_in    = stopped_upd;
         col_off_in    = col_off_upd;
         valid_char_in = valid_char_upd;
         type_char_in  = type_char_upd;
         time_in       = time_upd;
         date_in       = date_upd;
         cap_pos_in    = cap_pos_upd;
         cap_date_in   = cap_date_eff;
      end
   end

   // Mode and sync counter move only at a line end.
   always_comb begin
      logging_in = logging_ff;
      lines_in   = lines_ff;
      if (line_end) begin
         if (start_log) begin
            logging_in = 1'b1;
         end
         if (logging_ff) begin
            lines_in = sync ? 16'd0 : lines_next[15:0];
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         header_ff     <= '0;
         col_idx_ff    <= 4'd0;
         stopped_ff    <= 1'b0;
         col_off_ff    <= 3'd0;
         valid_char_ff <= BYTE_NUL;
         type_char_ff  <= BYTE_NUL;
         time_ff       <= '0;
         date_ff       <= '0;
         cap_pos_ff    <= CAP_IDLE;
         cap_date_ff   <= 1'b0;
         logging_ff    <= 1'b0;
         lines_ff      <= 16'd0;
      end else begin
         count_ff      <= count_in;
         header_ff     <= header_in;
         col_idx_ff    <= col_idx_in;
         stopped_ff    <= stopped_in;
         col_off_ff    <= col_off_in;
         valid_char_ff <= valid_char_in;
         type_char_ff  <= type_char_in;
         time_ff       <= time_in;
         date_ff       <= date_in;
         cap_pos_ff    <= cap_pos_in;
         cap_date_ff   <= cap_date_in;
         logging_ff    <= logging_in;
         lines_ff      <= lines_in;
      end
   end

endmodule

// ===== hdl/nmea_sentence_fix_filter_top.sv =====
// NMEA sentence fix filter, top level: input register, line parser, result
// register and configuration port. Depends on nsff_pkg and nsff_line_parser.
//
// The verdict for a line feed passes the input register, then the result register.
// Throughput: one byte per cycle; the parser stage updates its line state
// in one pass and stalls only while the result register is full and held.
// Reset: synchronous; clears the line state, returns to standby, clears the
// sync counter and sets sync_interval to 90.
module nmea_sentence_fix_filter_top
   import nsff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Byte stream in.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // Verdict records out.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [9:0] line_length, [11:10] sentence_kind,
                                     // [12] keep_line, [13] logging_started,
                                     // [20:14] fix_hour, [27:21] fix_minute,
                                     // [34:28] fix_second, [41:35] fix_day,
                                     // [48:42] fix_month, [55:49] fix_year,
                                     // [56] sync_request, [63:57] zero
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            rsp_valid_ff, rsp_valid_in;
   nsff_result_type rsp_data_ff, rsp_data_in;
   logic [15:0]     sync_interval_ff, sync_interval_in;

   logic            req_take, out_free, advance;
   logic            line_done;
   nsff_result_type line_result;

   // Handshake: the parser stage advances whenever it holds a byte and the result register can load.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   nsff_line_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .rx_byte       (in_byte_ff),
      .sync_interval (sync_interval_ff),
      .result_valid  (line_done),
      .result        (line_result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && line_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = line_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_data_ff.sync_request,
                        rsp_data_ff.fix_year,
                        rsp_data_ff.fix_month,
                        rsp_data_ff.fix_day,
                        rsp_data_ff.fix_second,
                        rsp_data_ff.fix_minute,
                        rsp_data_ff.fix_hour,
                        rsp_data_ff.logging_started,
                        rsp_data_ff.keep_line,
                        rsp_data_ff.sentence_kind,
                        rsp_data_ff.line_length};

   // Configuration register: one word, written in the access phase.
   assign csr_pready = 1'b1;

   always_comb begin
      sync_interval_in = sync_interval_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == CSR_SYNC_INTERVAL) begin
         sync_interval_in = csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_SYNC_INTERVAL) ?
                       {16'd0, sync_interval_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         sync_interval_ff <= 16'd90;
      end else begin
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         sync_interval_ff <= sync_interval_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
